// ===== rtl/htfd_pkg.sv =====
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the crc-8 step of the frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic VARIANT_PLAIN = 1'b0;
  localparam logic VARIANT_CRC   = 1'b1;
  localparam logic VARIANT_RESET = VARIANT_CRC;

  localparam int unsigned PROD_T_W = 31;
  localparam int unsigned PROD_H_W = 30;
  localparam int unsigned TEMP_W   = 15;
  localparam int unsigned HUM_W    = 14;

  localparam logic [14:0] T_SCALE_PLAIN  = 15'd16500;
  localparam logic [14:0] T_SCALE_CRC    = 15'd17500;
  localparam logic [13:0] H_SCALE        = 14'd10000;
  localparam logic [16:0] FULL_SCALE     = 17'd65535;
  localparam logic signed [15:0] T_OFFSET_PLAIN = 16'sd4000;
  localparam logic signed [15:0] T_OFFSET_CRC   = 16'sd4500;
  localparam logic signed [15:0] T_MIN   = -16'sd4000;
  localparam logic signed [15:0] T_MAX   = 16'sd12500;
  localparam logic [13:0] H_MAX          = 14'd10000;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TEMP_CRC = 2'd1,
    STATUS_HUM_CRC  = 2'd2,
    STATUS_RANGE    = 2'd3
  } status_e;

  typedef struct packed {
    logic        variant;
    logic [15:0] raw_temp;
    logic [15:0] raw_hum;
    status_e     crc_status;
  } frame_rec_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/htfd_front.sv =====
// ----------------------------------------------------------------------------
// htfd_front
// Byte intake: frame position, crc check and raw word assembly.
// ----------------------------------------------------------------------------
module htfd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_variant_i,
  input  logic                fire_i,
  input  logic [7:0]          data_byte_i,
  input  logic                frame_start_i,
  output logic                push_o,
  output htfd_pkg::frame_rec_t rec_o
);
  import htfd_pkg::*;

  logic        variant_q, variant_d;
  logic [2:0]  pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d, crc_eff, crc_upd;
  logic [15:0] temp_q, temp_d, hum_q, hum_d;
  logic        tbad_q, tbad_d;
  status_e     st;

  always_comb begin
    variant_d = cfg_we_i ? cfg_variant_i : variant_q;
    pos_eff   = frame_start_i ? '0 : pos_q;
    crc_eff   = frame_start_i ? CRC_INIT : crc_q;
    crc_upd   = crc8_update(crc_eff, data_byte_i);
    pos_d     = pos_q;
    crc_d     = crc_q;
    temp_d    = temp_q;
    hum_d     = hum_q;
    tbad_d    = tbad_q;
    push_o    = 1'b0;
    st        = STATUS_OK;
    if (fire_i) begin
      pos_d = pos_eff + 3'd1;
      crc_d = crc_eff;
      if (variant_q == VARIANT_PLAIN) begin
        case (pos_eff)
          3'd0: temp_d[15:8] = data_byte_i;
          3'd1: temp_d[7:0]  = data_byte_i;
          3'd2: hum_d[15:8]  = data_byte_i;
          3'd3: begin
            hum_d[7:0] = data_byte_i;
            pos_d      = '0;
            crc_d      = CRC_INIT;
            push_o     = 1'b1;
          end
          default: begin
            pos_d = '0;
            crc_d = CRC_INIT;
          end
        endcase
      end else begin
        case (pos_eff)
          3'd0: begin
            temp_d[15:8] = data_byte_i;
            crc_d        = crc_upd;
          end
          3'd1: begin
            temp_d[7:0] = data_byte_i;
            crc_d       = crc_upd;
          end
          3'd2: begin
            tbad_d = (data_byte_i != crc_eff);
            crc_d  = CRC_INIT;
          end
          3'd3: begin
            hum_d[15:8] = data_byte_i;
            crc_d       = crc_upd;
          end
          3'd4: begin
            hum_d[7:0] = data_byte_i;
            crc_d      = crc_upd;
          end
          3'd5: begin
            pos_d  = '0;
            crc_d  = CRC_INIT;
            push_o = 1'b1;
            if (tbad_q) begin
              st = STATUS_TEMP_CRC;
            end else if (data_byte_i != crc_eff) begin
              st = STATUS_HUM_CRC;
            end
          end
          default: begin
            pos_d = '0;
            crc_d = CRC_INIT;
          end
        endcase
      end
    end
  end

  always_comb begin
    rec_o.variant    = variant_q;
    rec_o.raw_temp   = temp_q;
    rec_o.raw_hum    = hum_d;
    rec_o.crc_status = st;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= VARIANT_RESET;
      pos_q     <= '0;
      crc_q     <= CRC_INIT;
      temp_q    <= '0;
      hum_q     <= '0;
      tbad_q    <= 1'b0;
    end else begin
      variant_q <= variant_d;
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      temp_q    <= temp_d;
      hum_q     <= hum_d;
      tbad_q    <= tbad_d;
    end
  end

endmodule

// ===== rtl/htfd_queue.sv =====
// ----------------------------------------------------------------------------
// htfd_queue
// Small fifo of finished frame records between intake and conversion.
// ----------------------------------------------------------------------------
module htfd_queue #(
  parameter int unsigned Depth = htfd_pkg::QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  htfd_pkg::frame_rec_t push_rec_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output htfd_pkg::frame_rec_t rec_o
);
  import htfd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  frame_rec_t            mem_q [Depth];
  logic [PtrW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == DepthCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rec_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastIdx) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastIdx) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/htfd_back.sv =====
// ----------------------------------------------------------------------------
// htfd_back
// Conversion pipeline: scale multiply, divide by full scale, range check.
// ----------------------------------------------------------------------------
module htfd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  htfd_pkg::frame_rec_t      q_rec_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [14:0]        temperature_centi_o,
  output logic [13:0]               humidity_centi_o,
  output logic                      reading_valid_o,
  output logic [1:0]                status_o
);
  import htfd_pkg::*;

  // multiply stage
  logic                a_valid_q;
  logic [PROD_T_W-1:0] prod_t_q, prod_t_d;
  logic [PROD_H_W-1:0] prod_h_q, prod_h_d;
  logic                a_var_q;
  status_e             a_st_q;
  logic                a_adv, b_adv;

  // output stage
  logic                b_valid_q;
  logic signed [14:0]  temp_q, temp_d;
  logic [13:0]         hum_q, hum_d;
  logic                rv_q, rv_d;
  status_e             st_q, st_d;

  logic [14:0]         qt;
  logic [16:0]         st_sum;
  logic [14:0]         tq;
  logic [13:0]         qh;
  logic [16:0]         sh_sum;
  logic [13:0]         hq;
  logic signed [15:0]  tval;
  logic                in_range;

  assign b_adv   = !b_valid_q || out_ready_i;
  assign a_adv   = !a_valid_q || b_adv;
  assign q_pop_o = a_adv && !q_empty_i;

  always_comb begin
    prod_t_d = PROD_T_W'(q_rec_i.raw_temp) *
               PROD_T_W'((q_rec_i.variant == VARIANT_PLAIN) ? T_SCALE_PLAIN : T_SCALE_CRC);
    prod_h_d = PROD_H_W'(q_rec_i.raw_hum) * PROD_H_W'(H_SCALE);
  end

  // x / 65535 = q + ((q + r) >= 65535) with q = x >> 16, r = x & 0xffff
  always_comb begin
    qt     = prod_t_q[PROD_T_W-1:16];
    st_sum = 17'(qt) + 17'(prod_t_q[15:0]);
    tq     = qt + 15'(st_sum >= FULL_SCALE);
    qh     = prod_h_q[PROD_H_W-1:16];
    sh_sum = 17'(qh) + 17'(prod_h_q[15:0]);
    hq     = qh + 14'(sh_sum >= FULL_SCALE);
    tval   = $signed({1'b0, tq}) -
             ((a_var_q == VARIANT_PLAIN) ? T_OFFSET_PLAIN : T_OFFSET_CRC);
    in_range = (tval >= T_MIN) && (tval <= T_MAX) && (hq <= H_MAX);
    if (a_st_q != STATUS_OK) begin
      temp_d = '0;
      hum_d  = '0;
      rv_d   = 1'b0;
      st_d   = a_st_q;
    end else begin
      temp_d = tval[14:0];
      hum_d  = hq;
      rv_d   = in_range;
      st_d   = in_range ? STATUS_OK : STATUS_RANGE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      prod_t_q <= prod_t_d;
      prod_h_q <= prod_h_d;
      a_var_q  <= q_rec_i.variant;
      a_st_q   <= q_rec_i.crc_status;
    end
    if (b_adv) begin
      temp_q <= temp_d;
      hum_q  <= hum_d;
      rv_q   <= rv_d;
      st_q   <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid_q <= !q_empty_i;
      end
      if (b_adv) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  assign out_valid_o         = b_valid_q;
  assign temperature_centi_o = temp_q;
  assign humidity_centi_o    = hum_q;
  assign reading_valid_o     = rv_q;
  assign status_o            = st_q;

endmodule

// ===== rtl/humidity_temp_frame_decoder_core.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_core
// Decodes sensor frames byte by byte into temperature and humidity readings.
// ----------------------------------------------------------------------------
// throughput: one byte word per cycle, in_ready_o low only while the queue is full
// after the frame's last byte is taken, the result word passes the queue write, the multiply
//   stage, and divide and range check into the output register
// reset: variant 1, byte position 0, crc 0xff, queue and pipeline empty
module humidity_temp_frame_decoder_core #(
  parameter int unsigned QueueDepth = htfd_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_sensor_variant_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [14:0] temperature_centi_o,
  output logic [13:0]        humidity_centi_o,
  output logic               reading_valid_o,
  output logic [1:0]         status_o
);
  import htfd_pkg::*;

  logic       fire, push, q_full, q_empty, pop;
  frame_rec_t push_rec, q_rec;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full;
  assign fire        = in_valid_i && in_ready_o;

  htfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_variant_i (cfg_sensor_variant_i),
    .fire_i        (fire),
    .data_byte_i   (data_byte_i),
    .frame_start_i (frame_start_i),
    .push_o        (push),
    .rec_o         (push_rec)
  );

  htfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .rec_o      (q_rec)
  );

  htfd_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_empty_i           (q_empty),
    .q_rec_i             (q_rec),
    .q_pop_o             (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .temperature_centi_o (temperature_centi_o),
    .humidity_centi_o    (humidity_centi_o),
    .reading_valid_o     (reading_valid_o),
    .status_o            (status_o)
  );

endmodule

// ===== rtl/htfd_checker.sv =====
// ----------------------------------------------------------------------------
// htfd_checker
// Port-level checks of the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module htfd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [14:0] temperature_centi_o,
  input logic [13:0]        humidity_centi_o,
  input logic               reading_valid_o,
  input logic [1:0]         status_o
);
  import htfd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(temperature_centi_o) &&
      $stable(humidity_centi_o) && $stable(status_o) && $stable(reading_valid_o))
    else $error("output word changed while stalled");

  a_valid_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reading_valid_o == (status_o == STATUS_OK)))
    else $error("reading_valid disagrees with status");

  a_crc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_TEMP_CRC || status_o == STATUS_HUM_CRC) |->
      (temperature_centi_o == '0) && (humidity_centi_o == '0))
    else $error("crc error word carries nonzero values");

  a_hum_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (humidity_centi_o <= H_MAX))
    else $error("humidity above full scale");

endmodule

bind humidity_temp_frame_decoder_core htfd_checker u_htfd_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Feeds directed and random sensor frames of both formats, with random gaps
// and stalls on both sides, and checks every reading against a local decoder.
// ----------------------------------------------------------------------------
module tb;
  import htfd_pkg::*;

  localparam int FRAME_LEN_PLAIN = 4;
  localparam int FRAME_LEN_CRC   = 6;
  localparam int PHASES          = 7;
  localparam int PHASE_BYTES     = 190;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 8;
  localparam int LIMIT_CYCLES    = 1_000_000;

  typedef struct {
    logic [7:0] value;
    logic       start;
  } frame_word_t;

  typedef struct {
    logic signed [14:0] temp;
    logic [13:0]        hum;
    logic               ok;
    status_e            status;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_sensor_variant_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic frame_start_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic cfg_ready_o;
  logic in_ready_o;
  logic out_valid_o;
  logic signed [14:0] temperature_centi_o;
  logic [13:0] humidity_centi_o;
  logic reading_valid_o;
  logic [1:0] status_o;

  frame_word_t byte_q[$];
  reading_t    reading_q[$];
  int          mismatches = 0;
  int          cycle_cnt = 0;
  int          tx_gap = 0;
  int          rx_stall = 0;
  int          rx_hold_len = 0;
  bit          in_idle_en = 1'b1;
  bit          out_idle_en = 1'b1;

  // decoder state
  logic        dec_variant = VARIANT_RESET;
  logic [2:0]  dec_pos = 3'd0;
  logic [7:0]  dec_crc = CRC_INIT;
  logic [15:0] dec_raw_t = 16'h0000;
  logic [15:0] dec_raw_h = 16'h0000;
  logic        dec_temp_bad = 1'b0;

  humidity_temp_frame_decoder_core i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_sensor_variant_i (cfg_sensor_variant_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .data_byte_i          (data_byte_i),
    .frame_start_i        (frame_start_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .temperature_centi_o  (temperature_centi_o),
    .humidity_centi_o     (humidity_centi_o),
    .reading_valid_o      (reading_valid_o),
    .status_o             (status_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic reading_t scale_reading(input logic v, input logic [15:0] rt,
                                             input logic [15:0] rh);
    reading_t r;
    int t;
    int h;
    if (v == VARIANT_PLAIN) begin
      t = int'(rt) * int'(T_SCALE_PLAIN) / int'(FULL_SCALE) - int'(T_OFFSET_PLAIN);
    end else begin
      t = int'(rt) * int'(T_SCALE_CRC) / int'(FULL_SCALE) - int'(T_OFFSET_CRC);
    end
    h = int'(rh) * int'(H_SCALE) / int'(FULL_SCALE);
    r.ok = (t >= int'(T_MIN)) && (t <= int'(T_MAX)) && (h <= int'(H_MAX));
    r.temp = t[14:0];
    r.hum = h[13:0];
    r.status = r.ok ? STATUS_OK : STATUS_RANGE;
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic start);
    reading_t r;
    if (start) begin
      dec_pos = 3'd0;
      dec_crc = CRC_INIT;
    end
    if (dec_variant == VARIANT_PLAIN) begin
      case (dec_pos)
        3'd0: dec_raw_t[15:8] = b;
        3'd1: dec_raw_t[7:0] = b;
        3'd2: dec_raw_h[15:8] = b;
        3'd3: begin
          dec_raw_h[7:0] = b;
          reading_q.push_back(scale_reading(VARIANT_PLAIN, dec_raw_t, dec_raw_h));
        end
        default: ;
      endcase
      if (dec_pos < 3'd3) begin
        dec_pos = dec_pos + 3'd1;
      end else begin
        dec_pos = 3'd0;
        dec_crc = CRC_INIT;
      end
    end else begin
      case (dec_pos)
        3'd0: begin
          dec_raw_t[15:8] = b;
          dec_crc = crc_step(dec_crc, b);
        end
        3'd1: begin
          dec_raw_t[7:0] = b;
          dec_crc = crc_step(dec_crc, b);
        end
        3'd2: begin
          dec_temp_bad = (b != dec_crc);
          dec_crc = CRC_INIT;
        end
        3'd3: begin
          dec_raw_h[15:8] = b;
          dec_crc = crc_step(dec_crc, b);
        end
        3'd4: begin
          dec_raw_h[7:0] = b;
          dec_crc = crc_step(dec_crc, b);
        end
        3'd5: begin
          r.temp = '0;
          r.hum = '0;
          r.ok = 1'b0;
          if (dec_temp_bad) begin
            r.status = STATUS_TEMP_CRC;
          end else if (b != dec_crc) begin
            r.status = STATUS_HUM_CRC;
          end else begin
            r = scale_reading(VARIANT_CRC, dec_raw_t, dec_raw_h);
          end
          reading_q.push_back(r);
        end
        default: ;
      endcase
      if (dec_pos < 3'd5) begin
        dec_pos = dec_pos + 3'd1;
      end else begin
        dec_pos = 3'd0;
        dec_crc = CRC_INIT;
      end
    end
  endtask

  function automatic int idle_gap(input bit en);
    int r;
    if (!en) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // byte driver
  always @(posedge clk_i) begin : drv
    logic nxt;
    frame_word_t w;
    nxt = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        decode_byte(data_byte_i, frame_start_i);
      end
      if (in_valid_i && !in_ready_o) begin
        nxt = 1'b1;
      end else if (tx_gap > 0) begin
        tx_gap--;
      end else if (byte_q.size() > 0) begin
        w = byte_q.pop_front();
        data_byte_i <= w.value;
        frame_start_i <= w.start;
        nxt = 1'b1;
        tx_gap = idle_gap(in_idle_en);
      end
    end
    in_valid_i <= nxt;
  end

  // reading monitor
  always @(posedge clk_i) begin : mon
    reading_t r;
    logic nxt;
    nxt = 1'b0;
    if (out_valid_o && out_ready_i) begin
      if (reading_q.size() == 0) begin
        $display("%0t: unexpected word temp %0d hum %0d valid %0d status %0d", $time,
                 temperature_centi_o, humidity_centi_o, reading_valid_o, status_o);
        mismatches++;
      end else begin
        r = reading_q.pop_front();
        if (temperature_centi_o !== r.temp) begin
          $display("%0t: temperature expected %0d got %0d", $time, r.temp,
                   temperature_centi_o);
          mismatches++;
        end
        if (humidity_centi_o !== r.hum) begin
          $display("%0t: humidity expected %0d got %0d", $time, r.hum, humidity_centi_o);
          mismatches++;
        end
        if (reading_valid_o !== r.ok) begin
          $display("%0t: reading valid expected %0d got %0d", $time, r.ok, reading_valid_o);
          mismatches++;
        end
        if (status_o !== r.status) begin
          $display("%0t: status expected %0d got %0d", $time, r.status, status_o);
          mismatches++;
        end
      end
    end
    if (rst_ni) begin
      if (rx_hold_len > 0) begin
        rx_hold_len--;
      end else if (rx_stall > 0) begin
        rx_stall--;
      end else begin
        rx_stall = idle_gap(out_idle_en);
        nxt = (rx_stall == 0);
      end
    end
    out_ready_i <= nxt;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic start);
    frame_word_t w;
    w.value = b;
    w.start = start;
    byte_q.push_back(w);
  endtask

  task automatic push_frame(input logic v, input logic [15:0] rt, input logic [15:0] rh,
                            input logic bad_t, input logic bad_h, input logic start,
                            input int n);
    logic [7:0] fr [6];
    logic [7:0] ct;
    logic [7:0] ch;
    ct = crc_step(crc_step(CRC_INIT, rt[15:8]), rt[7:0]);
    ch = crc_step(crc_step(CRC_INIT, rh[15:8]), rh[7:0]);
    if (bad_t) begin
      ct = ct ^ 8'($urandom_range(1, 255));
    end
    if (bad_h) begin
      ch = ch ^ 8'($urandom_range(1, 255));
    end
    if (v == VARIANT_PLAIN) begin
      fr = '{rt[15:8], rt[7:0], rh[15:8], rh[7:0], 8'h00, 8'h00};
    end else begin
      fr = '{rt[15:8], rt[7:0], ct, rh[15:8], rh[7:0], ch};
    end
    for (int i = 0; i < n; i++) begin
      push_byte(fr[i], start && (i == 0));
    end
  endtask

  function automatic logic [15:0] pick_raw();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1860, 1890));
      3: return 16'($urandom_range(63650, 63680));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic wait_idle();
    @(negedge clk_i);
    while (byte_q.size() != 0 || in_valid_i || reading_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_variant(input logic v);
    wait_idle();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_sensor_variant_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    dec_variant = v;
    @(negedge clk_i);
  endtask

  initial begin : stim
    int p;
    int n;
    int sel;
    int len;
    logic v;
    logic resync;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset format: range limits, no start mark, crc precedence, cut frame
    push_frame(VARIANT_CRC, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1, FRAME_LEN_CRC);
    push_frame(VARIANT_CRC, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0, FRAME_LEN_CRC);
    push_frame(VARIANT_CRC, 16'h8000, 16'h8000, 1'b1, 1'b1, 1'b1, FRAME_LEN_CRC);
    push_frame(VARIANT_CRC, 16'h6666, 16'h5555, 1'b0, 1'b0, 1'b1, FRAME_LEN_CRC - 1);
    // byte past the shorter frame is dropped
    write_variant(VARIANT_PLAIN);
    push_byte(8'hA5, 1'b0);
    push_frame(VARIANT_PLAIN, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, FRAME_LEN_PLAIN);
    push_frame(VARIANT_PLAIN, 16'h1234, 16'h5678, 1'b0, 1'b0, 1'b1, 2);
    push_frame(VARIANT_PLAIN, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, FRAME_LEN_PLAIN);

    for (p = 0; p < PHASES; p++) begin
      v = (p % 3 == 0) ? VARIANT_PLAIN : VARIANT_CRC;
      write_variant(v);
      in_idle_en = (p % 4 != 1) && (p % 4 != 3);
      out_idle_en = (p % 4 != 2) && (p % 4 != 3);
      len = (v == VARIANT_PLAIN) ? FRAME_LEN_PLAIN : FRAME_LEN_CRC;
      resync = 1'b1;
      while (byte_q.size() < PHASE_BYTES) begin
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
          push_frame(v, pick_raw(), pick_raw(), $urandom_range(0, 9) == 0,
                     $urandom_range(0, 9) == 0, resync || ($urandom_range(0, 9) < 7), len);
          resync = 1'b0;
        end else if (sel < 90) begin
          n = $urandom_range(1, 3);
          repeat (n) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          resync = 1'b1;
        end else begin
          push_frame(v, pick_raw(), pick_raw(), 1'b0, 1'b0, 1'b1, $urandom_range(1, len - 1));
          resync = 1'b1;
        end
      end
      // leave a frame open across the format change
      if ($urandom_range(0, 1) == 1) begin
        push_frame(v, pick_raw(), pick_raw(), 1'b0, 1'b0, 1'b1, $urandom_range(1, 3));
      end
    end

    // receiver blocked while the sender keeps going, so the input backs up
    write_variant(VARIANT_CRC);
    in_idle_en = 1'b0;
    out_idle_en = 1'b0;
    rx_hold_len = HOLD_CYCLES;
    for (n = 0; n < 60; n++) begin
      push_frame(VARIANT_CRC, pick_raw(), pick_raw(), 1'b0, $urandom_range(0, 9) == 0, 1'b1,
                 FRAME_LEN_CRC);
    end
    wait_idle();

    if (mismatches == 0 && reading_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
